// ===== rtl/lidar_rpm_tracker_scan_sizer_macros.svh =====
// Assertion macros shared by the scan sizer RTL.
`ifndef LIDAR_RPM_TRACKER_SCAN_SIZER_MACROS_SVH
`define LIDAR_RPM_TRACKER_SCAN_SIZER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define LRSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scan sizer: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define LRSS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scan sizer: next-cycle check failed");

`endif

// ===== rtl/lrss_pkg.sv =====
// Types, constants and table functions of the lidar scan sizer.
`default_nettype none
package lrss_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_RMUL,
    ST_RDIV,
    ST_IMUL1,
    ST_IMUL2,
    ST_KMUL,
    ST_DMUL,
    ST_PDIV,
    ST_OUT
  } state_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_ALPHA = 2'd0,
    REG_FIRING = 2'd1,
    REG_SLOTS = 2'd2,
    REG_INIT_RPM = 2'd3
  } cfg_reg_t;

  localparam logic [17:0] AZM_WRAP = 18'd36000;
  localparam logic [17:0] AZM_WRAP2 = 18'd72000;
  localparam logic [33:0] TIME_WRAP = 34'd3600000000;
  localparam logic [33:0] TIME_WRAP2 = 34'd7200000000;
  localparam logic [13:0] RATE_SCALE = 14'd10000;
  localparam logic [37:0] K_BASE = 38'd156250000000;
  localparam logic [16:0] ALPHA_ONE = 17'd65536;
  localparam logic [15:0] ROUND_HALF = 16'd32768;

  localparam logic [7:0] MODE_DUAL = 8'd57;
  localparam logic [7:0] MODEL_SINGLE_A = 8'd34;
  localparam logic [7:0] MODEL_SINGLE_B = 8'd36;
  localparam logic [7:0] MODEL_OCTAL_A = 8'd161;
  localparam logic [7:0] MODEL_OCTAL_B = 8'd99;

  // reset values of the registers
  localparam logic [16:0] ALPHA_RST = 17'd65470;
  localparam logic [29:0] FIRING_RST = 30'd139200000;
  localparam logic [6:0] SLOTS_RST = 7'd32;
  localparam logic [11:0] INIT_RPM_RST = 12'd600;

  // log2 of concurrent beams: 1, 2 or 8
  function automatic logic [1:0] beam_shift(input logic [7:0] model);
    logic [1:0] s;
    if (model == MODEL_SINGLE_A || model == MODEL_SINGLE_B) begin
      s = 2'd0;
    end else if (model == MODEL_OCTAL_A || model == MODEL_OCTAL_B) begin
      s = 2'd3;
    end else begin
      s = 2'd1;
    end
    return s;
  endfunction

  // packet multiplier of the return mode
  function automatic logic [1:0] mode_mult(input logic [7:0] mode, input logic [7:0] model);
    logic [1:0] m;
    if (mode != MODE_DUAL) begin
      m = 2'd1;
    end else if (model == MODEL_OCTAL_A || model == MODEL_OCTAL_B) begin
      m = 2'd3;
    end else begin
      m = 2'd2;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lidar_rpm_tracker_scan_sizer.sv =====
// Top level: rotation rate tracker and next-scan packet count.
//
// Channel  Dir  Handshake             Payload
// in_      in   in_tvalid/in_tready   tdata time,azimuth; tuser mode,model; tlast
// out_     out  out_tvalid/out_tready tdata count,rpm,mean
// cfg_     in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One item at a time through a bit-serial shift-add multiplier and a
// restoring divider, one bit per cycle each. A scan's first packet only
// records its time and azimuth, unless it is also the last. Other packets
// pass wrap reduction and, when the time delta is not zero, the rate multiply
// and divide and the two filter products; a scan's last packet adds the
// packet-count products, the packet-count divide and the result load.
// Synchronous active-low reset, no clearing pass. The result register holds
// while out_tready is low; the next item is taken meanwhile, and the
// sequencer waits in its final state only if the old result is still there.
`default_nettype none
`include "lidar_rpm_tracker_scan_sizer_macros.svh"
module lidar_rpm_tracker_scan_sizer #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // [31:0] time_of_hour_us, [47:32] azimuth_centideg
  input  wire logic [15:0] in_tuser,   // [7:0] return_mode, [15:8] model_id
  input  wire logic        in_tlast,   // last_in_scan
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // [15:0] count, [47:16] rpm q16, [79:48] mean time
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [29:0] cfg_data
);

  localparam int NW = 48 + 2 * FRAC_BITS;
  localparam int QW = (FRAC_BITS + 20 > 32) ? FRAC_BITS + 20 : 32;
  localparam int CW = $clog2(NW + 1);
  localparam int PW = FRAC_BITS + 20;
  localparam int CRW = FRAC_BITS + 2;

  // whole rpm into the fixed-point estimate, saturated
  function automatic logic [31:0] rpm_load(input logic [11:0] w);
    logic [47:0] v;
    v = 48'(w) << FRAC_BITS;
    return (|v[47:32]) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  lrss_pkg::state_t state_r, state_nxt;

  // configuration
  logic [16:0] alpha_r;
  logic [29:0] fc_r;
  logic [6:0]  slots_r;

  // tracker state
  logic [31:0] t_r, prev_t_r, first_r, rpm_r;
  logic [15:0] prev_azm_r;
  logic [7:0]  mode_r, model_r;
  logic        last_r, pending_r;
  logic [CRW-1:0] carry_r;

  // wrap reduction
  logic [17:0] dazm_r;
  logic [33:0] dtime_r;

  // serial multiplier
  logic [61:0] acc_r, mcand_r;
  logic [29:0] mplier_r;
  logic [47:0] k_r;

  // serial divider
  logic [NW-1:0] num_r;
  logic [62:0]   rem_r;
  logic [61:0]   den_r;
  logic [QW-1:0] q_r;
  logic          ovf_r, div_pkts_r;
  logic [CW-1:0] cnt_r;

  // result register
  logic        out_valid_r;
  logic [15:0] out_count_r;
  logic [31:0] out_rpm_r, out_mean_r;

  logic in_acc, out_free, mul_done, div_done, delta_done, mul_st, div_st, out_load;
  logic [16:0] a_clamp, a_comp;
  logic [31:0] rate_sat;
  logic [62:0] rem_sh;
  logic        q_bit, q_top;
  logic [PW-1:0]  pkts_v;
  logic [PW:0]    sum_v;
  logic [20:0]    whole_v;
  logic [FRAC_BITS-1:0] frac_v;
  logic [22:0]    whole23;
  logic [22:0]    count_v;
  logic [CRW-1:0] frac_x, carry_v;
  logic [1:0]     mult_v;
  logic [32:0]    mean_sum;

  assign in_acc     = in_tvalid & in_tready;
  assign out_free   = ~out_valid_r | out_tready;
  assign mul_done   = (mplier_r == '0);
  assign div_done   = (cnt_r == '0);
  assign delta_done = (dazm_r < lrss_pkg::AZM_WRAP) && (dtime_r < lrss_pkg::TIME_WRAP);
  assign a_clamp    = alpha_r[16] ? lrss_pkg::ALPHA_ONE : alpha_r;
  assign a_comp     = lrss_pkg::ALPHA_ONE - a_clamp;
  assign rate_sat   = ovf_r ? 32'hFFFF_FFFF : q_r[31:0];
  assign rem_sh     = {rem_r[61:0], num_r[NW-1]};
  assign q_bit      = (rem_sh >= {1'b0, den_r});
  assign q_top      = div_pkts_r ? q_r[PW-1] : q_r[31];
  assign cfg_ready  = 1'b1;

  // packet count from the divider result
  always_comb begin
    pkts_v  = ovf_r ? {PW{1'b1}} : q_r[PW-1:0];
    sum_v   = {1'b0, pkts_v} + (PW + 1)'(carry_r);
    whole_v = sum_v[PW:FRAC_BITS];
    frac_v  = sum_v[FRAC_BITS-1:0];
    whole23 = {2'b00, whole_v};
    frac_x  = {2'b00, frac_v};
    mult_v  = lrss_pkg::mode_mult(mode_r, model_r);
    unique case (mult_v)
      2'd3: begin
        count_v = whole23 + (whole23 << 1);
        carry_v = frac_x + (frac_x << 1);
      end
      2'd2: begin
        count_v = whole23 << 1;
        carry_v = frac_x << 1;
      end
      default: begin
        count_v = whole23;
        carry_v = frac_x;
      end
    endcase
    mean_sum = {1'b0, first_r} + {1'b0, t_r};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lrss_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (pending_r) begin
            state_nxt = in_tlast ? lrss_pkg::ST_KMUL : lrss_pkg::ST_IDLE;
          end else begin
            state_nxt = lrss_pkg::ST_DELTA;
          end
        end
      end
      lrss_pkg::ST_DELTA: begin
        if (delta_done) begin
          if (dtime_r == '0) begin
            state_nxt = last_r ? lrss_pkg::ST_KMUL : lrss_pkg::ST_IDLE;
          end else begin
            state_nxt = lrss_pkg::ST_RMUL;
          end
        end
      end
      lrss_pkg::ST_RMUL:  if (mul_done) state_nxt = lrss_pkg::ST_RDIV;
      lrss_pkg::ST_RDIV:  if (div_done) state_nxt = lrss_pkg::ST_IMUL1;
      lrss_pkg::ST_IMUL1: if (mul_done) state_nxt = lrss_pkg::ST_IMUL2;
      lrss_pkg::ST_IMUL2: begin
        if (mul_done) state_nxt = last_r ? lrss_pkg::ST_KMUL : lrss_pkg::ST_IDLE;
      end
      lrss_pkg::ST_KMUL:  if (mul_done) state_nxt = lrss_pkg::ST_DMUL;
      lrss_pkg::ST_DMUL:  if (mul_done) state_nxt = lrss_pkg::ST_PDIV;
      lrss_pkg::ST_PDIV:  if (div_done) state_nxt = lrss_pkg::ST_OUT;
      lrss_pkg::ST_OUT:   if (out_free) state_nxt = lrss_pkg::ST_IDLE;
      default:            state_nxt = lrss_pkg::ST_IDLE;
    endcase
  end

  // state decode
  always_comb begin
    in_tready = (state_r == lrss_pkg::ST_IDLE);
    mul_st    = (state_r == lrss_pkg::ST_RMUL) || (state_r == lrss_pkg::ST_IMUL1) ||
                (state_r == lrss_pkg::ST_IMUL2) || (state_r == lrss_pkg::ST_KMUL) ||
                (state_r == lrss_pkg::ST_DMUL);
    div_st    = (state_r == lrss_pkg::ST_RDIV) || (state_r == lrss_pkg::ST_PDIV);
    out_load  = (state_r == lrss_pkg::ST_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrss_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath and tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r     <= lrss_pkg::ALPHA_RST;
      fc_r        <= lrss_pkg::FIRING_RST;
      slots_r     <= lrss_pkg::SLOTS_RST;
      rpm_r       <= rpm_load(lrss_pkg::INIT_RPM_RST);
      prev_t_r    <= '0;
      prev_azm_r  <= '0;
      first_r     <= '0;
      carry_r     <= '0;
      pending_r   <= 1'b1;
      mplier_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_valid) begin
        unique case (lrss_pkg::cfg_reg_t'(cfg_index))
          lrss_pkg::REG_ALPHA:    alpha_r <= cfg_data[16:0];
          lrss_pkg::REG_FIRING:   fc_r    <= cfg_data;
          lrss_pkg::REG_SLOTS:    slots_r <= cfg_data[6:0];
          lrss_pkg::REG_INIT_RPM: rpm_r   <= rpm_load(cfg_data[11:0]);
        endcase
      end

      // item capture and raw deltas
      if (in_acc) begin
        t_r        <= in_tdata[31:0];
        mode_r     <= in_tuser[7:0];
        model_r    <= in_tuser[15:8];
        last_r     <= in_tlast;
        prev_t_r   <= in_tdata[31:0];
        prev_azm_r <= in_tdata[47:32];
        dazm_r     <= 18'(in_tdata[47:32]) + lrss_pkg::AZM_WRAP2 - 18'(prev_azm_r);
        dtime_r    <= 34'(in_tdata[31:0]) + lrss_pkg::TIME_WRAP2 - 34'(prev_t_r);
        if (pending_r) begin
          first_r   <= in_tdata[31:0];
          pending_r <= 1'b0;
        end
      end

      // wrap reduction, one subtract per cycle
      if (state_r == lrss_pkg::ST_DELTA) begin
        if (dazm_r >= lrss_pkg::AZM_WRAP) dazm_r <= dazm_r - lrss_pkg::AZM_WRAP;
        if (dtime_r >= lrss_pkg::TIME_WRAP) dtime_r <= dtime_r - lrss_pkg::TIME_WRAP;
      end

      // shift-add multiplier step
      if (mul_st && !mul_done) begin
        if (mplier_r[0]) acc_r <= acc_r + mcand_r;
        mcand_r  <= mcand_r << 1;
        mplier_r <= mplier_r >> 1;
      end

      // restoring divider step
      if (div_st && !div_done) begin
        rem_r <= q_bit ? (rem_sh - {1'b0, den_r}) : rem_sh;
        q_r   <= {q_r[QW-2:0], q_bit};
        if (q_top) ovf_r <= 1'b1;
        num_r <= num_r << 1;
        cnt_r <= cnt_r - 1'b1;
      end

      // smoothed estimate after both products
      if (state_r == lrss_pkg::ST_IMUL2 && mul_done) rpm_r <= acc_r[47:16];

      // result register
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_count_r <= (|count_v[22:16]) ? 16'hFFFF : count_v[15:0];
        out_rpm_r   <= rpm_r;
        out_mean_r  <= mean_sum[32:1];
        carry_r     <= carry_v;
        pending_r   <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      // operand loads on entry to a state
      if (state_nxt != state_r) begin
        unique case (state_nxt)
          lrss_pkg::ST_RMUL: begin
            acc_r    <= '0;
            mcand_r  <= 62'(lrss_pkg::RATE_SCALE);
            mplier_r <= 30'(dazm_r[15:0]);
          end
          lrss_pkg::ST_RDIV: begin
            num_r      <= {acc_r[28:0], {(NW - 29){1'b0}}};
            rem_r      <= '0;
            q_r        <= '0;
            ovf_r      <= 1'b0;
            div_pkts_r <= 1'b0;
            cnt_r      <= CW'(29 + FRAC_BITS);
            den_r      <= (62'(dtime_r) << 2) + (62'(dtime_r) << 1);
          end
          lrss_pkg::ST_IMUL1: begin
            acc_r    <= 62'(lrss_pkg::ROUND_HALF);
            mcand_r  <= 62'(rpm_r);
            mplier_r <= 30'(a_clamp);
          end
          lrss_pkg::ST_IMUL2: begin
            mcand_r  <= 62'(rate_sat);
            mplier_r <= 30'(a_comp);
          end
          lrss_pkg::ST_KMUL: begin
            acc_r    <= '0;
            mcand_r  <= 62'(lrss_pkg::K_BASE);
            mplier_r <= 30'(slots_r);
          end
          lrss_pkg::ST_DMUL: begin
            k_r      <= {3'b000, acc_r[44:0]} << lrss_pkg::beam_shift(model_r);
            acc_r    <= '0;
            mcand_r  <= 62'(rpm_r);
            mplier_r <= fc_r;
          end
          lrss_pkg::ST_PDIV: begin
            num_r      <= {k_r, {(2 * FRAC_BITS){1'b0}}};
            rem_r      <= '0;
            q_r        <= '0;
            ovf_r      <= 1'b0;
            div_pkts_r <= 1'b1;
            cnt_r      <= CW'(NW);
            den_r      <= acc_r;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_mean_r, out_rpm_r, out_count_r};

  // a waiting result is never overwritten
  `LRSS_ASSERT_NXT(a_out_hold, (state_r == lrss_pkg::ST_OUT) && out_valid_r && !out_tready, (state_r == lrss_pkg::ST_OUT))
  // one item at a time; only a scan's opening packet that is not its last frees the input at once
  `LRSS_ASSERT_NXT(a_one_item, in_acc && !(pending_r && !in_tlast), !in_tready)
  // rate divide keeps its remainder below the divisor
  `LRSS_ASSERT_IMP(a_rem_bound, (state_r == lrss_pkg::ST_RDIV), (rem_r < {1'b0, den_r}))

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the lidar rotation-rate tracker and scan sizer.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

  localparam int FRAC = 16;
  localparam longint unsigned PKT_CAP = (64'd1 << (FRAC + 20)) - 64'd1;
  localparam int QUIET_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 400;

  typedef struct packed {
    logic [15:0] count;
    logic [31:0] rpm;
    logic [31:0] mean_us;
  } scan_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [15:0] in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [29:0] cfg_data;

  // tracker shadow state and shadow registers
  logic [16:0] alpha_reg;
  logic [29:0] firing_reg;
  logic [6:0]  slots_reg;
  logic [11:0] init_rpm_reg;
  logic [31:0] prev_us;
  logic [15:0] prev_azm;
  logic [31:0] rpm_q16;
  longint unsigned carry_q;
  logic        scan_open_next;
  logic [31:0] scan_first_us;

  scan_result_t scan_results_due[$];
  int  errors;
  bit  send_idle;
  bit  recv_idle;

  lidar_rpm_tracker_scan_sizer #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] whole_to_q16(logic [11:0] whole);
    longint unsigned v;
    v = longint'(whole) << FRAC;
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic longint unsigned beams_of(logic [7:0] model);
    if (model == lrss_pkg::MODEL_SINGLE_A || model == lrss_pkg::MODEL_SINGLE_B) return 1;
    if (model == lrss_pkg::MODEL_OCTAL_A || model == lrss_pkg::MODEL_OCTAL_B) return 8;
    return 2;
  endfunction

  function automatic longint unsigned mult_of(logic [7:0] mode, logic [7:0] model);
    if (mode != lrss_pkg::MODE_DUAL) return 1;
    return (model == lrss_pkg::MODEL_OCTAL_A || model == lrss_pkg::MODEL_OCTAL_B) ? 3 : 2;
  endfunction

  // floor(k * 2^(2F) / d), capped
  function automatic longint unsigned packets_per_scan(longint unsigned k,
                                                       longint unsigned d);
    longint unsigned q, r;
    q = k / d;
    r = k % d;
    if (q > PKT_CAP) return PKT_CAP;
    for (int i = 0; i < 2 * FRAC; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= d) begin
        r = r - d;
        q = q + 1;
      end
      if (q > PKT_CAP) return PKT_CAP;
    end
    return q;
  endfunction

  function automatic void reset_tracker();
    alpha_reg = lrss_pkg::ALPHA_RST;
    firing_reg = lrss_pkg::FIRING_RST;
    slots_reg = lrss_pkg::SLOTS_RST;
    init_rpm_reg = lrss_pkg::INIT_RPM_RST;
    prev_us = '0;
    prev_azm = '0;
    rpm_q16 = whole_to_q16(lrss_pkg::INIT_RPM_RST);
    carry_q = 0;
    scan_open_next = 1'b1;
    scan_first_us = '0;
  endfunction

  // track one packet header; queue a result on the scan's last packet
  function automatic void track_packet(logic [31:0] stamp, logic [15:0] azm,
                                       logic [7:0] mode, logic [7:0] model, logic last);
    longint unsigned dazm, dus, rate, a, mult, k, d, pkts, sum, whole, cnt;
    scan_result_t res;
    if (scan_open_next) begin
      scan_first_us = stamp;
      scan_open_next = 1'b0;
    end else begin
      dazm = (longint'(azm) + 72000 - longint'(prev_azm)) % 36000;
      dus = (longint'(stamp) + 64'd7200000000 - longint'(prev_us)) % 64'd3600000000;
      if (dus != 0) begin
        rate = ((dazm * 10000) << FRAC) / (6 * dus);
        a = (alpha_reg > 65536) ? 65536 : longint'(alpha_reg);
        if (rate > 64'hFFFF_FFFF) rate = 64'hFFFF_FFFF;
        rpm_q16 = 32'((a * longint'(rpm_q16) + (65536 - a) * rate + 32768) >> 16);
      end
    end
    prev_us = stamp;
    prev_azm = azm;
    if (!last) return;
    mult = mult_of(mode, model);
    k = 64'd156250000000 * beams_of(model) * longint'(slots_reg);
    d = longint'(rpm_q16) * longint'(firing_reg);
    pkts = (d == 0) ? PKT_CAP : packets_per_scan(k, d);
    sum = pkts + carry_q;
    whole = sum >> FRAC;
    carry_q = mult * (sum & ((64'd1 << FRAC) - 1));
    cnt = mult * whole;
    res.count = (cnt > 65535) ? 16'hFFFF : cnt[15:0];
    res.rpm = rpm_q16;
    res.mean_us = 32'((longint'(scan_first_us) + longint'(stamp)) >> 1);
    scan_results_due.push_back(res);
    scan_open_next = 1'b1;
  endfunction

  // send one header; valid stays high into the next item when no gap is drawn
  task automatic send_pkt(logic [31:0] stamp, logic [15:0] azm, logic [7:0] mode,
                          logic [7:0] model, logic last);
    int gap;
    gap = send_idle ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {azm, stamp};
    in_tuser <= {model, mode};
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_packet(stamp, azm, mode, model, last);
  endtask

  // stop sending and let every due result drain, then let the block settle
  task automatic drain_and_settle();
    in_tvalid <= 1'b0;
    while (scan_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(lrss_pkg::cfg_reg_t idx, logic [29:0] value);
    drain_and_settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    unique case (idx)
      lrss_pkg::REG_ALPHA: alpha_reg = value[16:0];
      lrss_pkg::REG_FIRING: firing_reg = value;
      lrss_pkg::REG_SLOTS: slots_reg = value[6:0];
      lrss_pkg::REG_INIT_RPM: begin
        init_rpm_reg = value[11:0];
        rpm_q16 = whole_to_q16(value[11:0]);
      end
    endcase
  endtask

  function automatic logic [7:0] pick_model();
    logic [7:0] models [8] = '{8'd33, 8'd34, 8'd36, 8'd40, 8'd49,
                               lrss_pkg::MODEL_OCTAL_A, lrss_pkg::MODEL_OCTAL_B, 8'd7};
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    return models[$urandom_range(0, 7)];
  endfunction

  // one plausible scan: steady rotation with random jitter
  task automatic send_scan(int len);
    logic [31:0] stamp;
    logic [15:0] azm;
    logic [7:0] mode, model;
    stamp = $urandom_range(0, 32'd3599000000);
    azm = $urandom_range(0, 35999);
    mode = ($urandom_range(0, 1) != 0) ? lrss_pkg::MODE_DUAL : 8'($urandom);
    model = pick_model();
    for (int i = 0; i < len; i++) begin
      send_pkt(stamp, azm, mode, model, i == len - 1);
      stamp = (stamp + $urandom_range(1, 5000)) % 32'd3600000000;
      azm = (azm + $urandom_range(0, 2000)) % 36000;
    end
  endtask

  task automatic send_noise();
    send_pkt($urandom, 16'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic test_directed();
    send_idle = 0;
    // ordinary scan, then azimuth and time wraps
    send_pkt(32'd1000, 16'd100, 8'd55, 8'd33, 1'b0);
    send_pkt(32'd2333, 16'd580, 8'd55, 8'd33, 1'b0);
    send_pkt(32'd3599999990, 16'd35990, 8'd55, 8'd33, 1'b0);
    send_pkt(32'd5, 16'd10, lrss_pkg::MODE_DUAL, 8'd34, 1'b1);
    // single-packet scans over single, two-beam, octal and unknown models and both modes
    send_pkt(32'd10, 16'd0, lrss_pkg::MODE_DUAL, 8'd36, 1'b1);
    send_pkt(32'd20, 16'd0, lrss_pkg::MODE_DUAL, 8'd40, 1'b1);
    send_pkt(32'd30, 16'd0, lrss_pkg::MODE_DUAL, 8'd49, 1'b1);
    send_pkt(32'd40, 16'd0, lrss_pkg::MODE_DUAL, lrss_pkg::MODEL_OCTAL_A, 1'b1);
    send_pkt(32'd50, 16'd0, 8'd0, lrss_pkg::MODEL_OCTAL_B, 1'b1);
    send_pkt(32'd60, 16'd0, lrss_pkg::MODE_DUAL, lrss_pkg::MODEL_OCTAL_B, 1'b1);
    send_pkt(32'd70, 16'd0, 8'hFF, 8'hFF, 1'b1);
    // zero time delta, then out-of-range fields
    send_pkt(32'd5000, 16'd300, 8'd55, 8'd33, 1'b0);
    send_pkt(32'd5000, 16'd900, 8'd55, 8'd33, 1'b0);
    send_pkt(32'hFFFF_FFFF, 16'hFFFF, 8'd55, 8'd33, 1'b0);
    send_pkt(32'd0, 16'd0, 8'd55, 8'd33, 1'b0);
    send_pkt(32'hFFFF_FFFF, 16'hFFFF, 8'd55, 8'd33, 1'b1);
    // fast spin: large azimuth step over one microsecond
    send_pkt(32'd100, 16'd0, lrss_pkg::MODE_DUAL, lrss_pkg::MODEL_OCTAL_A, 1'b0);
    send_pkt(32'd101, 16'd35999, lrss_pkg::MODE_DUAL, lrss_pkg::MODEL_OCTAL_A, 1'b1);
    drain_and_settle();
  endtask

  task automatic test_register_extremes();
    logic [29:0] alphas [4] = '{30'd0, 30'd65536, 30'h1FFFF, 30'd32768};
    send_idle = 1;
    for (int i = 0; i < 4; i++) begin
      write_reg(lrss_pkg::REG_ALPHA, alphas[i]);
      send_scan($urandom_range(2, 6));
    end
    write_reg(lrss_pkg::REG_ALPHA, 30'd0);
    write_reg(lrss_pkg::REG_FIRING, 30'd1);
    send_scan(3);
    write_reg(lrss_pkg::REG_FIRING, 30'h3FFF_FFFF);
    send_scan(3);
    write_reg(lrss_pkg::REG_SLOTS, 30'd1);
    send_scan(3);
    write_reg(lrss_pkg::REG_SLOTS, 30'd127);
    send_scan(3);
    write_reg(lrss_pkg::REG_SLOTS, 30'd0);
    send_scan(3);
    // zero estimate held by a frozen filter saturates the count
    write_reg(lrss_pkg::REG_ALPHA, 30'd65536);
    write_reg(lrss_pkg::REG_INIT_RPM, 30'd0);
    send_scan(2);
    write_reg(lrss_pkg::REG_INIT_RPM, 30'd4095);
    send_scan(2);
    write_reg(lrss_pkg::REG_INIT_RPM, 30'd1);
    send_scan(2);
    write_reg(lrss_pkg::REG_INIT_RPM, 30'h3FFF_FFFF);
    send_scan(2);
    // back to a realistic setting
    write_reg(lrss_pkg::REG_ALPHA, 30'd65470);
    write_reg(lrss_pkg::REG_FIRING, 30'd139200000);
    write_reg(lrss_pkg::REG_SLOTS, 30'd32);
    write_reg(lrss_pkg::REG_INIT_RPM, 30'd600);
  endtask

  task automatic test_random_scans();
    int sent;
    sent = 0;
    while (sent < 400) begin
      if ($urandom_range(0, 19) == 0) begin
        send_idle = $urandom_range(0, 1);
        recv_idle = $urandom_range(0, 1);
      end
      if ($urandom_range(0, 7) == 0) begin
        send_noise();
        sent++;
      end else begin
        int len;
        len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 12);
        send_scan(len);
        sent += len;
      end
      // sender holds off until the block has delivered everything
      if (sent > 200 && sent < 215) begin
        in_tvalid <= 1'b0;
        while (scan_results_due.size() != 0) @(posedge clk);
      end
      if (sent > 250 && sent < 265) begin
        drain_and_settle();
        write_reg(lrss_pkg::REG_ALPHA, $urandom_range(0, 65536));
        write_reg(lrss_pkg::REG_FIRING, $urandom_range(1000000, 400000000));
        write_reg(lrss_pkg::REG_SLOTS, $urandom_range(1, 64));
        write_reg(lrss_pkg::REG_INIT_RPM, $urandom_range(300, 1200));
      end
    end
  endtask

  // result side: random stalls, compare each item with the oldest due result
  initial begin
    int n;
    scan_result_t got, want;
    out_tready = 1'b0;
    forever begin
      n = recv_idle ? $urandom_range(0, 18) : 0;
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got = {out_tdata[15:0], out_tdata[47:16], out_tdata[79:48]};
      if (scan_results_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result count=%0d rpm=%h mean=%0d", $time,
                 got.count, got.rpm, got.mean_us);
      end else begin
        want = scan_results_due.pop_front();
        if (got.count !== want.count) begin
          errors++;
          $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
        end
        if (got.rpm !== want.rpm) begin
          errors++;
          $display("%0t: rpm expected %h actual %h", $time, want.rpm, got.rpm);
        end
        if (got.mean_us !== want.mean_us) begin
          errors++;
          $display("%0t: mean expected %0d actual %0d", $time, want.mean_us,
                   got.mean_us);
        end
      end
    end
  end

  // watchdog on cycles with no item moving on any channel
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("lidar_rpm_tracker_scan_sizer: mismatch");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    send_idle = 0;
    recv_idle = 1;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    in_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = lrss_pkg::REG_ALPHA;
    cfg_data = '0;
    reset_tracker();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_random_scans();
    drain_and_settle();
    if (errors == 0) begin
      $display("lidar_rpm_tracker_scan_sizer: match");
    end else begin
      $display("lidar_rpm_tracker_scan_sizer: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/lrss_pkg.sv
rtl/lidar_rpm_tracker_scan_sizer.sv
verif/testbench.sv
